/* sv/cursor_linked_list_engine_top_assert.svh */
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_top_assert
// assertion macros for the cursor linked list engine
// ----------------------------------------------------------------------------
`ifndef CURSOR_LINKED_LIST_ENGINE_TOP_ASSERT_SVH
`define CURSOR_LINKED_LIST_ENGINE_TOP_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define CLL_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define CLL_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* sv/cll_pkg.sv */
// ----------------------------------------------------------------------------
// cll_pkg
// shared codes for the cursor linked list engine
// ----------------------------------------------------------------------------
package cll_pkg;

   localparam logic [2:0] KIND_MAKE   = 3'd0;
   localparam logic [2:0] KIND_INSERT = 3'd1;
   localparam logic [2:0] KIND_DELETE = 3'd2;
   localparam logic [2:0] KIND_FIND   = 3'd3;
   localparam logic [2:0] KIND_FREE   = 3'd4;
   localparam logic [2:0] KIND_READ   = 3'd5;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE  = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   localparam int INDEX_WIDTH = 10;
   localparam int NODES = 1 << INDEX_WIDTH;
   localparam int VALUE_WIDTH = 32;

   typedef logic [2:0] kind_type;
   typedef logic [1:0] status_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;

endpackage

/* sv/cursor_linked_list_engine_top.sv */
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_top
// node pool of values and links holding linked lists and a free list
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  req_*   | in        | req_valid / req_stall
//  rsp_*   | out       | rsp_valid / rsp_stall
//
// after reset a clearing pass writes every node, req_stall high
// one item at a time; each ram read goes through S_WAIT (address registered,
// then data registered), and find, delete, list freeing and make walk a list
// one node read at a time
// req_stall stays high from acceptance until the result beat is taken
module cursor_linked_list_engine_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [2:0]                 req_kind,
   input  logic [9:0]                 req_list_head,
   input  logic [9:0]                 req_position,
   input  logic signed [31:0]         req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output cll_pkg::status_type        rsp_status,
   output logic [9:0]                 rsp_position_out,
   output logic [9:0]                 rsp_prev_out,
   output logic signed [31:0]         rsp_value_out,
   output logic [9:0]                 rsp_next_out
);
   import cll_pkg::*;

   localparam int AW = INDEX_WIDTH;
   localparam int SW = AW + 1;

   // sequencer states
   localparam logic [4:0] S_CLEAR  = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_WAIT   = 5'd2;   // ram read of addr_ff in flight
   localparam logic [4:0] S_RESP   = 5'd3;
   localparam logic [4:0] S_FL0    = 5'd4;   // free list: got link[l]
   localparam logic [4:0] S_FLW    = 5'd5;   // free list: got link[p]
   localparam logic [4:0] S_FLF    = 5'd6;   // free list: freeing l
   localparam logic [4:0] S_AL0    = 5'd7;   // alloc: n = head
   localparam logic [4:0] S_AL1    = 5'd8;   // alloc: got link[n]
   localparam logic [4:0] S_INS0   = 5'd9;   // insert: got link[pos]
   localparam logic [4:0] S_INS1   = 5'd10;  // insert: write node n
   localparam logic [4:0] S_INS2   = 5'd11;  // insert: write link[pos]
   localparam logic [4:0] S_SRL    = 5'd12;  // search: got link[l]
   localparam logic [4:0] S_SRV    = 5'd13;  // search: got value and link of nxt
   localparam logic [4:0] S_DEL0   = 5'd14;  // delete: rewire pred
   localparam logic [4:0] S_DEL1   = 5'd15;  // delete: free hit
   localparam logic [4:0] S_RDV    = 5'd16;  // read: got value, link

   logic [4:0] state_ff, state_in, ret_ff, ret_in;
   index_type addr_ff, addr_in;
   index_type lnk_wdata;
   logic [VALUE_WIDTH-1:0] val_wdata;
   logic lnk_we, val_we;
   index_type lnk_rd;
   logic [VALUE_WIDTH-1:0] val_rd;

   index_type head0_ff, head0_in;       // cached link[0]
   index_type p_ff, p_in, n_ff, n_in, nxt_ff, nxt_in;
   logic [SW-1:0] steps_ff, steps_in;
   kind_type kind_ff, kind_in;
   index_type l_ff, l_in, pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] v_ff, v_in;
   logic rsp_valid_ff, rsp_valid_in;
   status_type status_ff, status_in;
   index_type po_ff, po_in, pr_ff, pr_in, nx_ff, nx_in;
   logic [VALUE_WIDTH-1:0] vo_ff, vo_in;

   cll_ram #(.WIDTH(AW), .DEPTH(NODES)) u_link (
      .clock(clock), .wr_en(lnk_we), .addr(addr_ff),
      .wr_data(lnk_wdata), .rd_data(lnk_rd));
   cll_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(NODES)) u_value (
      .clock(clock), .wr_en(val_we), .addr(addr_ff),
      .wr_data(val_wdata), .rd_data(val_rd));

   always_comb begin
      logic [AW:0] nx1;
      logic [SW-1:0] step_nx;
      state_in = state_ff; ret_in = ret_ff; addr_in = addr_ff;
      lnk_we = 1'b0; val_we = 1'b0; lnk_wdata = '0; val_wdata = '0;
      head0_in = head0_ff; p_in = p_ff; n_in = n_ff; nxt_in = nxt_ff;
      steps_in = steps_ff; kind_in = kind_ff; l_in = l_ff; pos_in = pos_ff;
      v_in = v_ff; rsp_valid_in = rsp_valid_ff; status_in = status_ff;
      po_in = po_ff; pr_in = pr_ff; nx_in = nx_ff; vo_in = vo_ff;
      nx1 = {1'b0, addr_ff} + (AW+1)'(1);
      step_nx = steps_ff + SW'(1);
      case (state_ff)
         S_CLEAR: begin
            lnk_we = 1'b1; val_we = 1'b1;
            lnk_wdata = nx1[AW-1:0];
            addr_in = nx1[AW-1:0];
            if (addr_ff == AW'(NODES - 1)) begin
               state_in = S_IDLE;
               head0_in = AW'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;
               l_in = req_list_head;
               pos_in = req_position;
               v_in = req_value;
               status_in = STATUS_OK; po_in = '0; pr_in = '0;
               nx_in = '0; vo_in = '0;
               steps_in = '0;
               case (req_kind)
                  KIND_MAKE, KIND_FREE: begin
                     if (req_list_head != '0) begin
                        addr_in = req_list_head;
                        ret_in = S_FL0; state_in = S_WAIT;
                     end else if (req_kind == KIND_MAKE) begin
                        state_in = S_AL0;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  KIND_INSERT: begin
                     if (req_position == '0) state_in = S_RESP;
                     else state_in = S_AL0;
                  end
                  KIND_DELETE, KIND_FIND: begin
                     if (req_list_head == '0) begin
                        status_in = STATUS_NOT_FOUND; state_in = S_RESP;
                     end else begin
                        p_in = req_list_head;
                        addr_in = req_list_head;
                        ret_in = S_SRL; state_in = S_WAIT;
                     end
                  end
                  KIND_READ: begin
                     addr_in = req_position;
                     po_in = req_position;
                     ret_in = S_RDV; state_in = S_WAIT;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_WAIT: state_in = ret_ff;
         S_FL0: begin
            if (lnk_rd == '0) state_in = S_FLF;
            else begin
               p_in = lnk_rd; addr_in = lnk_rd; ret_in = S_FLW; state_in = S_WAIT;
            end
         end
         S_FLW: begin
            // lnk_rd is next of p; link p onto the free list
            lnk_we = 1'b1; lnk_wdata = head0_ff;
            head0_in = p_ff;
            steps_in = step_nx;
            if (lnk_rd == '0 || step_nx >= SW'(NODES)) begin
               addr_in = l_ff; state_in = S_FLF;
            end else begin
               p_in = lnk_rd; addr_in = lnk_rd; ret_in = S_FLW; state_in = S_WAIT;
            end
         end
         S_FLF: begin
            lnk_we = 1'b1; lnk_wdata = head0_ff;
            head0_in = l_ff;
            if (kind_ff == KIND_MAKE) state_in = S_AL0;
            else state_in = S_RESP;
         end
         S_AL0: begin
            n_in = head0_ff;
            if (head0_ff == '0) begin
               // empty free list leaves link[0] as it is
               status_in = STATUS_NO_FREE; state_in = S_RESP;
            end else begin
               addr_in = head0_ff; ret_in = S_AL1; state_in = S_WAIT;
            end
         end
         S_AL1: begin
            head0_in = lnk_rd;
            if (kind_ff == KIND_MAKE) begin
               lnk_we = 1'b1; val_we = 1'b1;
               po_in = n_ff; state_in = S_RESP;
            end else begin
               addr_in = pos_ff; ret_in = S_INS0; state_in = S_WAIT;
            end
         end
         S_INS0: begin
            // node n is written before pos, so pos equal to n ends self-linked
            nxt_in = lnk_rd;
            addr_in = n_ff; state_in = S_INS1;
         end
         S_INS1: begin
            lnk_we = 1'b1; lnk_wdata = nxt_ff;
            val_we = 1'b1; val_wdata = v_ff;
            addr_in = pos_ff; state_in = S_INS2;
         end
         S_INS2: begin
            lnk_we = 1'b1; lnk_wdata = n_ff;
            po_in = n_ff; state_in = S_RESP;
         end
         S_SRL: begin
            if (lnk_rd == '0) begin
               status_in = STATUS_NOT_FOUND; pr_in = p_ff; state_in = S_RESP;
            end else begin
               nxt_in = lnk_rd; addr_in = lnk_rd;
               ret_in = S_SRV; state_in = S_WAIT;
            end
         end
         S_SRV: begin
            // one read gives both value[nxt] and link[nxt]
            if (val_rd == v_ff) begin
               po_in = nxt_ff; pr_in = p_ff;
               if (kind_ff == KIND_DELETE) begin
                  n_in = nxt_ff; nxt_in = lnk_rd;
                  addr_in = p_ff; state_in = S_DEL0;
               end else state_in = S_RESP;
            end else begin
               steps_in = step_nx;
               p_in = nxt_ff;
               if (step_nx >= SW'(NODES) || lnk_rd == '0) begin
                  status_in = STATUS_NOT_FOUND; pr_in = nxt_ff; state_in = S_RESP;
               end else begin
                  nxt_in = lnk_rd; addr_in = lnk_rd;
                  ret_in = S_SRV; state_in = S_WAIT;
               end
            end
         end
         S_DEL0: begin
            lnk_we = 1'b1; lnk_wdata = nxt_ff;
            addr_in = n_ff; state_in = S_DEL1;
         end
         S_DEL1: begin
            lnk_we = 1'b1; lnk_wdata = head0_ff;
            head0_in = n_ff; state_in = S_RESP;
         end
         S_RDV: begin
            // link[0] lives in the head register
            vo_in = val_rd;
            nx_in = (pos_ff == '0) ? head0_ff : lnk_rd;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff) rsp_valid_in = 1'b1;
            else if (!rsp_stall) begin
               rsp_valid_in = 1'b0; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; addr_ff <= '0;
         rsp_valid_ff <= 1'b0; head0_ff <= '0; ret_ff <= S_IDLE;
      end else begin
         state_ff <= state_in; addr_ff <= addr_in;
         rsp_valid_ff <= rsp_valid_in; head0_ff <= head0_in; ret_ff <= ret_in;
      end
      p_ff <= p_in; n_ff <= n_in; nxt_ff <= nxt_in; steps_ff <= steps_in;
      kind_ff <= kind_in; l_ff <= l_in; pos_ff <= pos_in; v_ff <= v_in;
      status_ff <= status_in; po_ff <= po_in; pr_ff <= pr_in;
      nx_ff <= nx_in; vo_ff <= vo_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_position_out = po_ff;
   assign rsp_prev_out = pr_ff;
   assign rsp_next_out = nx_ff;
   assign rsp_value_out = vo_ff;

`include "cursor_linked_list_engine_top_assert.svh"

   `CLL_ASSERT_IMP(a_rsp_in_resp, clock, reset, rsp_valid, state_ff == S_RESP,
      "result beat outside response state")
   `CLL_ASSERT_IMP(a_busy_no_rsp, clock, reset, state_ff == S_IDLE, !rsp_valid,
      "result pending while idle")
   `CLL_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid,
      "result beat dropped while stalled")

endmodule

/* sv/cll_ram.sv */
// ----------------------------------------------------------------------------
// cll_ram
// single port ram, one write plus one registered read of the same address per cycle
// ----------------------------------------------------------------------------
module cll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule
